@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the scanner frame unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LSS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scanner assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

`endif

@@ hw/rtl/lss_pkg.sv @@
// Shared types and constants of the scanner frame unit.
package lss_pkg;

   // Percent scale and duration limit
   localparam int          PCT_FULL = 100;
   localparam logic [13:0] DUR_MAX  = 14'd10000;

   // Divide by PCT_FULL as multiply and shift; exact for products up to 6400
   localparam logic [12:0] PCT_RECIP    = 13'd5243;
   localparam int          PCT_RECIP_SH = 19;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;

   localparam logic [CSR_INDEX_W-1:0] CSR_SWEEP_TIME     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_DELAY      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLIDER_PERCENT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIP_LENGTH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_RED       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_GREEN     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_BLUE      = 3'd6;

   // Animation phases
   localparam logic [1:0] PH_HOLD_START = 2'd0;
   localparam logic [1:0] PH_SWEEP_UP   = 2'd1;
   localparam logic [1:0] PH_HOLD_END   = 2'd2;
   localparam logic [1:0] PH_SWEEP_DOWN = 2'd3;

   // Shared divider: quotient is known to stay below 2**DIV_Q_W
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 20;
   localparam int DIV_Q_W   = 8;
   localparam int DIV_SH_W  = DIV_DEN_W + DIV_Q_W - 1;
   localparam int DIV_CNT_W = 3;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_Q_W-1:0] quot;
   } div_rsp_type;

endpackage

@@ hw/rtl/led_strip_scanner_frame_unit.sv @@
// Scanner frame unit: phase timing and per-pixel frame generation.
//
// Input channel req_*: one transfer is a tick carrying the milliseconds
// elapsed since the previous tick. Output channel rsp_*: one transfer per
// pixel of the active strip, pixel 0 first, rsp_frame_last on the final one.
// Configuration csr_*: a register is written on any clock with csr_write high.
//
// After a tick is taken the sequencer advances the phase, one phase boundary
// at a time, then runs setup (two multiply steps and one division). Each
// pixel is then emitted directly when it is dark or at full color; when it
// lies on the faded slider body it takes one pass of the shared divider per
// color channel. req_stall is high from the accepted tick until the last
// pixel has entered the output register. The output register holds its
// pixel while rsp_stall is high; the sequencer then waits with the next
// pixel ready.
// Reset, synchronous and active high, returns the phase to hold at start,
// clears the phase timer and loads the default configuration.
module led_strip_scanner_frame_unit import lss_pkg::*; #(
   parameter int MAX_PIXELS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [15:0]            req_elapsed_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [5:0]             rsp_pixel_index,
   output logic [7:0]             rsp_pixel_red,
   output logic [7:0]             rsp_pixel_green,
   output logic [7:0]             rsp_pixel_blue,
   output logic                   rsp_frame_last,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "assert_macros.svh"

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_STEP  = 10'b00_0000_0010,
      S_MUL1  = 10'b00_0000_0100,
      S_MUL2  = 10'b00_0000_1000,
      S_PDIV  = 10'b00_0001_0000,
      S_PWAIT = 10'b00_0010_0000,
      S_PIX   = 10'b00_0100_0000,
      S_FDIV  = 10'b00_1000_0000,
      S_FWAIT = 10'b01_0000_0000,
      S_EMIT  = 10'b10_0000_0000
   } state_type;

   // Configuration registers
   logic [13:0] sweep_ff, delay_ff;
   logic [6:0]  pct_ff, len_cfg_ff;
   logic [7:0]  red_ff, green_ff, blue_ff;

   // Sequencer state
   state_type   state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [16:0] pt_ff, pt_in;
   logic [5:0]  pix_ff, pix_in;
   logic [1:0]  k_ff, k_in;

   // Working values
   logic [6:0]        w_ff, w_in;
   logic [12:0]       wnum_ff, wnum_in;
   logic signed [9:0] pos_ff, pos_in;
   logic [24:0]       prod1_ff, prod1_in;
   logic [31:0]       prod2_ff, prod2_in;
   logic [19:0]       den_ff, den_in;
   logic [6:0]        wd_ff, wd_in;
   logic [7:0]        chan_ff [3];
   logic [7:0]        chan_in [3];

   // Output register
   logic       out_valid_ff, out_valid_in;
   logic [5:0] out_index_ff, out_index_in;
   logic [7:0] out_red_ff, out_red_in;
   logic [7:0] out_green_ff, out_green_in;
   logic [7:0] out_blue_ff, out_blue_in;
   logic       out_last_ff, out_last_in;

   // Clamped configuration
   logic [13:0] sweep_dur, delay_dur, dur_cur;
   logic [6:0]  len_c, pct_c;
   logic [7:0]  pct_sum;
   logic [5:0]  h;
   logic [7:0]  col [3];
   logic [7:0]  col_sel;
   logic [12:0] wnum;
   logic [25:0] wprod;
   logic [14:0] fnum;

   // Pixel geometry
   logic signed [9:0] ii, ls, hs, qv, lo, hi, dpix, wd_calc;
   logic              last_pix, lit, force_on, full_on, fade_on;

   div_req_type div_req;
   div_rsp_type div_rsp;

   lss_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Range clamps
   always_comb begin
      sweep_dur = (sweep_ff == '0) ? 14'd1 : ((sweep_ff > DUR_MAX) ? DUR_MAX : sweep_ff);
      delay_dur = (delay_ff == '0) ? 14'd1 : ((delay_ff > DUR_MAX) ? DUR_MAX : delay_ff);
      dur_cur   = phase_ff[0] ? sweep_dur : delay_dur;
      if (len_cfg_ff == '0) begin
         len_c = 7'd1;
      end else if (len_cfg_ff > 7'(MAX_PIXELS)) begin
         len_c = 7'(MAX_PIXELS);
      end else begin
         len_c = len_cfg_ff;
      end
      pct_c   = (pct_ff > 7'(PCT_FULL)) ? 7'(PCT_FULL) : pct_ff;
      pct_sum = 8'(PCT_FULL) + {1'b0, pct_c};
      h       = w_ff[6:1];
      col[0]  = red_ff;
      col[1]  = green_ff;
      col[2]  = blue_ff;
      col_sel = col[k_ff];
      wnum    = 13'(pct_c) * 13'(len_c);
      // slider width: percent of strip, divided by 100 via reciprocal
      wprod   = 26'(wnum_ff) * 26'(PCT_RECIP);
      fnum    = 15'(col_sel) * 15'(wd_ff);
   end

   // Slider geometry for the current pixel
   always_comb begin
      ii       = $signed({4'b0, pix_ff});
      ls       = $signed({3'b0, len_c});
      hs       = $signed({4'b0, h});
      qv       = ls - pos_ff;
      last_pix = pix_ff == 6'(len_c - 7'd1);
      lo       = '0;
      hi       = '0;
      dpix     = '0;
      lit      = 1'b0;
      force_on = 1'b0;
      case (phase_ff)
         PH_HOLD_START: begin
            force_on = pix_ff == '0;
         end
         PH_HOLD_END: begin
            force_on = last_pix;
         end
         PH_SWEEP_UP: begin
            lo       = pos_ff - hs;
            hi       = pos_ff + hs;
            lit      = (ii >= lo) && (ii <= hi);
            dpix     = hi - ii;
            force_on = (hi >= ls) && last_pix;
         end
         PH_SWEEP_DOWN: begin
            lo       = qv - hs;
            hi       = qv + hs;
            lit      = (ii >= lo) && (ii <= hi);
            dpix     = ii - lo;
            force_on = (lo <= 10'sd0) && (pix_ff == '0);
         end
         default: begin
            force_on = 1'b0;
         end
      endcase
      full_on = force_on || (lit && (w_ff == '0));
      fade_on = lit && !full_on;
      wd_calc = $signed({3'b0, w_ff}) - dpix;
   end

   // Shared divider requests
   always_comb begin
      div_req.start = (state_ff == S_PDIV) || (state_ff == S_FDIV);
      if (state_ff == S_PDIV) begin
         div_req.num = prod2_ff;
         div_req.den = den_ff;
      end else begin
         div_req.num = DIV_NUM_W'(fnum);
         div_req.den = DIV_DEN_W'(w_ff);
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pt_in        = pt_ff;
      pix_in       = pix_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      wnum_in      = wnum_ff;
      pos_in       = pos_ff;
      prod1_in     = prod1_ff;
      prod2_in     = prod2_ff;
      den_in       = den_ff;
      wd_in        = wd_ff;
      chan_in      = chan_ff;
      out_index_in = out_index_ff;
      out_red_in   = out_red_ff;
      out_green_in = out_green_ff;
      out_blue_in  = out_blue_ff;
      out_last_in  = out_last_ff;
      // output register drains on a transfer
      out_valid_in = out_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pt_in    = pt_ff + 17'(req_elapsed_ms);
               pix_in   = '0;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            wnum_in = wnum;
            // one phase boundary per cycle
            if (pt_ff >= 17'(dur_cur)) begin
               pt_in    = pt_ff - 17'(dur_cur);
               phase_in = phase_ff + 2'd1;
            end else begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            w_in     = wprod[PCT_RECIP_SH +: 7];
            prod1_in = 25'(pt_ff) * 25'(pct_sum);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            prod2_in = 32'(prod1_ff) * 32'(len_c);
            den_in   = 20'(dur_cur) * 20'(PCT_FULL);
            state_in = S_PDIV;
         end
         S_PDIV: begin
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            if (div_rsp.done) begin
               pos_in   = $signed({2'b0, div_rsp.quot}) - hs;
               state_in = S_PIX;
            end
         end
         S_PIX: begin
            k_in  = '0;
            wd_in = wd_calc[6:0];
            if (fade_on) begin
               state_in = S_FDIV;
            end else begin
               for (int c = 0; c < 3; c++) begin
                  chan_in[c] = full_on ? col[c] : 8'd0;
               end
               state_in = S_EMIT;
            end
         end
         S_FDIV: begin
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            if (div_rsp.done) begin
               chan_in[k_ff] = div_rsp.quot;
               if (k_ff == 2'd2) begin
                  state_in = S_EMIT;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_FDIV;
               end
            end
         end
         S_EMIT: begin
            // load when the output register is empty or draining
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_index_in = pix_ff;
               out_red_in   = chan_ff[0];
               out_green_in = chan_ff[1];
               out_blue_in  = chan_ff[2];
               out_last_in  = last_pix;
               if (last_pix) begin
                  state_in = S_IDLE;
               end else begin
                  pix_in   = pix_ff + 6'd1;
                  state_in = S_PIX;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_HOLD_START;
         pt_ff        <= '0;
         out_valid_ff <= 1'b0;
         sweep_ff     <= 14'd1000;
         delay_ff     <= 14'd500;
         pct_ff       <= 7'd20;
         len_cfg_ff   <= 7'd64;
         red_ff       <= 8'd255;
         green_ff     <= 8'd0;
         blue_ff      <= 8'd0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pt_ff        <= pt_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_SWEEP_TIME:     sweep_ff   <= csr_wdata;
               CSR_END_DELAY:      delay_ff   <= csr_wdata;
               CSR_SLIDER_PERCENT: pct_ff     <= csr_wdata[6:0];
               CSR_STRIP_LENGTH:   len_cfg_ff <= csr_wdata[6:0];
               CSR_BASE_RED:       red_ff     <= csr_wdata[7:0];
               CSR_BASE_GREEN:     green_ff   <= csr_wdata[7:0];
               CSR_BASE_BLUE:      blue_ff    <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      k_ff         <= k_in;
      w_ff         <= w_in;
      wnum_ff      <= wnum_in;
      pos_ff       <= pos_in;
      prod1_ff     <= prod1_in;
      prod2_ff     <= prod2_in;
      den_ff       <= den_in;
      wd_ff        <= wd_in;
      chan_ff      <= chan_in;
      out_index_ff <= out_index_in;
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
      out_last_ff  <= out_last_in;
   end

   assign req_stall       = state_ff != S_IDLE;
   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_index = out_index_ff;
   assign rsp_pixel_red   = out_red_ff;
   assign rsp_pixel_green = out_green_ff;
   assign rsp_pixel_blue  = out_blue_ff;
   assign rsp_frame_last  = out_last_ff;

   // The divider is only started when it is free
   `LSS_ASSERT_NOW(a_div_free, div_req.start, !div_rsp.busy)
   // A divider result only arrives while the sequencer waits for it
   `LSS_ASSERT_NOW(a_div_done_wait, div_rsp.done, (state_ff == S_PWAIT) || (state_ff == S_FWAIT))
   // A pixel waits while the output register is held
   `LSS_ASSERT_NEXT(a_emit_hold, (state_ff == S_EMIT) && out_valid_ff && rsp_stall,
      state_ff == S_EMIT)

endmodule

@@ hw/rtl/lss_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module lss_div import lss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_NUM_W-1:0] rem_ff, rem_in;
   logic [DIV_SH_W-1:0]  dsh_ff, dsh_in;
   logic [DIV_Q_W-1:0]   quot_ff, quot_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 fit;

   // Trial subtract of the shifted divisor
   assign fit = rem_ff >= DIV_NUM_W'(dsh_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         rem_in  = div_req.num;
         dsh_in  = {div_req.den, {(DIV_Q_W-1){1'b0}}};
         quot_in = '0;
         cnt_in  = DIV_CNT_W'(DIV_Q_W - 1);
      end else if (busy_ff) begin
         if (fit) begin
            rem_in = rem_ff - DIV_NUM_W'(dsh_ff);
         end
         quot_in = {quot_ff[DIV_Q_W-2:0], fit};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule
